// ----- hw/rtl/lfo_pkg.sv -----
package lfo_pkg;

  localparam int PHASE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int IDX_W    = 32;
  localparam int FREQ_W   = 21;
  localparam int RATE_W   = 18;
  localparam int SHAPE_W  = 3;
  localparam int OUT_W    = 16;
  localparam int PERIOD_W = 28;
  localparam int PROD_W   = 52;
  localparam int DIV_W    = PROD_W + PHASE_BITS;
  localparam int VAL_W    = 17;
  localparam int SIDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int ONE_Q14  = 16384;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_SINE      = 3'd0,
    SHAPE_TRIANGLE  = 3'd1,
    SHAPE_SQUARE    = 3'd2,
    SHAPE_RAMP_UP   = 3'd3,
    SHAPE_RAMP_DOWN = 3'd4
  } shape_e;

  typedef enum logic [1:0] {
    REG_SHAPE = 2'd0,
    REG_FREQ  = 2'd1,
    REG_RATE  = 2'd2
  } reg_e;

  // One divider step's payload: partial remainder and the dividend/quotient shifter.
  typedef struct packed {
    logic                valid;
    logic [PERIOD_W-1:0] rem;
    logic [DIV_W-1:0]    sh;
  } div_stage_t;

  typedef struct packed {
    logic [SHAPE_W-1:0] shape;
    logic               neg;
    logic               zero;
  } lfo_cfg_t;

  typedef logic [14:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave sine, odd Taylor series to x^11 in Q30, rounded to Q14.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) + 32768) >> 16;
      if (v > ONE_Q14) begin
        v = ONE_Q14;
      end
      tab[k] = 15'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ----- hw/rtl/lfo_div_step.sv -----
module lfo_div_step import lfo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [PERIOD_W-1:0] period_i,
  input  div_stage_t          in_i,
  output div_stage_t          out_o
);

  logic [PERIOD_W:0] trial;
  logic              ge;
  div_stage_t        out_d;
  div_stage_t        out_q;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial       = {in_i.rem, in_i.sh[DIV_W-1]};
    ge          = trial >= {1'b0, period_i};
    out_d.valid = in_i.valid;
    out_d.rem   = ge ? PERIOD_W'(trial - {1'b0, period_i}) : trial[PERIOD_W-1:0];
    out_d.sh    = {in_i.sh[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ----- hw/rtl/lfo_shape.sv -----
module lfo_shape import lfo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  lfo_cfg_t              cfg_i,
  input  logic                  valid_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output logic                  valid_o,
  output logic [OUT_W-1:0]      value_o
);

  localparam int QB   = PHASE_BITS - 2;
  localparam int FULL = 1 << PHASE_BITS;

  logic [QB-1:0]             pos;
  logic [31:0]               idx_full;
  logic [SIDX_W-1:0]         sidx;
  logic [PHASE_BITS:0]       ph2;
  logic [PHASE_BITS:0]       tri_span;
  logic [PHASE_BITS+15:0]    tri_wide;
  logic [PHASE_BITS+15:0]    ramp_wide;

  logic                      a_valid_q;
  logic [1:0]                a_quad_q;
  logic [SIDX_W-1:0]         a_sidx_q;
  logic signed [VAL_W-1:0]   a_tri_q;
  logic signed [VAL_W-1:0]   a_ramp_q;
  logic                      a_hi_q;

  logic [SIDX_W-1:0]         tidx;
  logic signed [VAL_W-1:0]   sine_v;
  logic signed [VAL_W-1:0]   v;
  logic signed [VAL_W-1:0]   v_neg;
  logic                      b_valid_q;
  logic [OUT_W-1:0]          b_value_q;

  always_comb begin
    pos       = phase_i[QB-1:0];
    idx_full  = 32'(pos) * 32'(SINE_TABLE_DEPTH) + 32'((1 << QB) / 2);
    idx_full  = idx_full >> QB;
    if (idx_full > 32'(SINE_TABLE_DEPTH)) begin
      sidx = SIDX_W'(SINE_TABLE_DEPTH);
    end else begin
      sidx = idx_full[SIDX_W-1:0];
    end
    ph2       = {phase_i, 1'b0};
    tri_span  = (ph2 >= (PHASE_BITS+1)'(FULL)) ? ph2 - (PHASE_BITS+1)'(FULL)
                                               : (PHASE_BITS+1)'(FULL) - ph2;
    tri_wide  = ({15'd0, tri_span} << 15) >> PHASE_BITS;
    ramp_wide = ({16'd0, phase_i} << 15) >> PHASE_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_quad_q  <= phase_i[PHASE_BITS-1 -: 2];
      a_sidx_q  <= sidx;
      a_tri_q   <= $signed(tri_wide[VAL_W-1:0]) - VAL_W'(ONE_Q14);
      a_ramp_q  <= $signed(ramp_wide[VAL_W-1:0]) - VAL_W'(ONE_Q14);
      a_hi_q    <= phase_i[PHASE_BITS-1];
      b_value_q <= v_neg[OUT_W-1:0];
    end
  end

  // Odd quadrants read the table mirrored, the second half is negated.
  always_comb begin
    tidx = a_quad_q[0] ? SIDX_W'(SINE_TABLE_DEPTH) - a_sidx_q : a_sidx_q;
    sine_v = $signed({2'b00, SINE_TAB[tidx]});
    if (a_quad_q[1]) begin
      sine_v = -sine_v;
    end
    case (cfg_i.shape)
      SHAPE_SINE:      v = sine_v;
      SHAPE_TRIANGLE:  v = a_tri_q;
      SHAPE_SQUARE:    v = a_hi_q ? VAL_W'(ONE_Q14) : -VAL_W'(ONE_Q14);
      SHAPE_RAMP_UP:   v = a_ramp_q;
      SHAPE_RAMP_DOWN: v = -a_ramp_q;
      default:         v = '0;
    endcase
    if (cfg_i.zero) begin
      v_neg = '0;
    end else if (cfg_i.neg) begin
      v_neg = -v;
    end else begin
      v_neg = v;
    end
  end

  assign valid_o = b_valid_q;
  assign value_o = b_value_q;

endmodule

// ----- hw/rtl/lfo_waveform_generator.sv -----
// Low frequency oscillator evaluated per sample index.
// The input channel (sample_index_i) takes one index per transfer; the output
// channel returns one Q2.14 lfo_value_o per index, in order.
// The configuration port is APB-style: shape at 0x0, frequency in milli-hertz
// at 0x4, sample rate in hertz at 0x8; write it only while the pipeline is empty.
// The pipeline is one multiply stage, 68 restoring divider steps that give both
// the modulo by rate*1000 and the phase fraction, one step per stage, and two
// stages of waveform lookup and selection ending in the output register.
// Throughput is one item per cycle when the receiver does not stall.
// Reset empties the pipeline and loads sine, 1000 mHz and 44100 Hz.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// the input is not ready; no transfer is lost or repeated.
module lfo_waveform_generator import lfo_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     sample_index_valid_i,
  output logic                     sample_index_ready_o,
  input  logic [IDX_W-1:0]         sample_index_i,
  output logic                     lfo_value_valid_o,
  input  logic                     lfo_value_ready_i,
  output logic signed [OUT_W-1:0]  lfo_value_o
);

  logic [SHAPE_W-1:0]  shape_q;
  logic [FREQ_W-1:0]   freq_q;
  logic [RATE_W-1:0]   rate_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] period_d;
  logic [FREQ_W-1:0]   mag;
  logic                wr;
  lfo_cfg_t            cfg;

  logic                en;
  logic                mul_valid_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   prod_full;
  div_stage_t          chain [0:DIV_W];
  logic                out_valid;
  logic [OUT_W-1:0]    out_value;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= SHAPE_SINE;
      freq_q   <= FREQ_W'(1000);
      rate_q   <= RATE_W'(44100);
      period_q <= PERIOD_W'(44100000);
    end else begin
      period_q <= period_d;
      if (wr) begin
        case (reg_e'(paddr[3:2]))
          REG_SHAPE: shape_q <= pwdata[SHAPE_W-1:0];
          REG_FREQ:  freq_q  <= pwdata[FREQ_W-1:0];
          REG_RATE:  rate_q  <= pwdata[RATE_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_SHAPE: prdata = 32'(shape_q);
      REG_FREQ:  prdata = 32'(freq_q);
      REG_RATE:  prdata = 32'(rate_q);
      default:   prdata = '0;
    endcase
  end

  // A zero rate counts as one hertz.
  assign period_d  = PERIOD_W'((rate_q == '0) ? RATE_W'(1) : rate_q) * PERIOD_W'(1000);
  assign mag       = freq_q[FREQ_W-1] ? FREQ_W'(-freq_q) : freq_q;
  assign cfg.shape = shape_q;
  assign cfg.neg   = freq_q[FREQ_W-1];
  assign cfg.zero  = (mag == '0);

  assign en                   = !out_valid || lfo_value_ready_i;
  assign sample_index_ready_o = en;
  assign prod_full            = PROD_W'(sample_index_i) * PROD_W'(mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= sample_index_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_full;
    end
  end

  // The dividend is the product followed by the phase bits, so the last
  // PHASE_BITS quotient bits are the phase fraction of the remainder.
  assign chain[0].valid = mul_valid_q;
  assign chain[0].rem   = '0;
  assign chain[0].sh    = {prod_q, {PHASE_BITS{1'b0}}};

  for (genvar s = 0; s < DIV_W; s++) begin : g_step
    lfo_div_step u_step (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .period_i (period_q),
      .in_i     (chain[s]),
      .out_o    (chain[s+1])
    );
  end

  lfo_shape u_shape (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (chain[DIV_W].valid),
    .phase_i (chain[DIV_W].sh[PHASE_BITS-1:0]),
    .valid_o (out_valid),
    .value_o (out_value)
  );

  assign lfo_value_valid_o = out_valid;
  assign lfo_value_o       = $signed(out_value);

endmodule
